/* hw/rtl/modular_square_root_assert.svh */
// ----------------------------------------------------------------------------
// modular_square_root_assert
// assertion macros for the modular square root block
// ----------------------------------------------------------------------------
`ifndef MODULAR_SQUARE_ROOT_ASSERT_SVH
`define MODULAR_SQUARE_ROOT_ASSERT_SVH
`ifndef SYNTHESIS
`define MSQRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MSQRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MSQRT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MSQRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/msqrt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msqrt_pkg
// shared constants, command and status types of the modular square root
// ----------------------------------------------------------------------------
package msqrt_pkg;
    localparam int WIDTH = 31;
    localparam int CW    = $clog2(WIDTH);

    localparam logic [0:0] CFG_MODULUS = 1'b0;
    localparam logic [0:0] CFG_NONRES  = 1'b1;

    typedef enum logic [2:0] {
        M_RED_A, M_RED_NR, M_POW_R, M_POW_X, M_U, M_XD, M_DD, M_TB
    } t_mop;

    typedef enum logic [1:0] {
        P_AQ, P_AQH, P_BQ, P_BD
    } t_psel;

    typedef enum logic [1:0] {
        O_A, O_X, O_FAIL
    } t_osel;

    typedef struct packed {
        logic  load;
        logic  q_half;
        logic  q_shift;
        logic  u_init;
        logic  cc_inc;
        logic  c_set;
        logic  mul_go;
        t_mop  mop;
        logic  pow_go;
        t_psel psel;
        logic  st_b;
        logic  st_x;
        logic  st_t;
        logic  out_go;
        t_osel osel;
    } t_cmd;

    typedef struct packed {
        logic p_lt2;
        logic p_two;
        logic a_zero;
        logic pe_zero;
        logic pe_lsb;
        logic pr_one;
        logic q_lsb;
        logic t_one;
        logic u_one;
        logic cc_last;
        logic mul_busy;
        logic mul_done;
        logic out_free;
    } t_stat;
endpackage
`default_nettype wire

/* hw/rtl/msqrt_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msqrt_mul
// bit-serial modular multiplier, also reduces y modulo m in reduce mode
// ----------------------------------------------------------------------------
module msqrt_mul (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_go,
    input  wire logic                         i_red,
    input  wire logic [msqrt_pkg::WIDTH-1:0]  i_x,
    input  wire logic [msqrt_pkg::WIDTH-1:0]  i_y,
    input  wire logic [msqrt_pkg::WIDTH-1:0]  i_m,
    output logic                              o_busy,
    output logic                              o_done,
    output logic      [msqrt_pkg::WIDTH-1:0]  o_res
);
    import msqrt_pkg::*;

    logic             r_busy, n_busy;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [WIDTH-1:0] r_x, r_y;
    logic             r_red;
    logic [WIDTH:0]   dbl, sum;
    logic [WIDTH-1:0] half, addend;
    logic             ybit;

    always_comb begin
        dbl = {r_acc, 1'b0};
        if (dbl >= {1'b0, i_m}) begin
            dbl = dbl - {1'b0, i_m};
        end
        half = dbl[WIDTH-1:0];
        ybit = r_y[r_cnt];
        if (r_red) begin
            addend = {{(WIDTH-1){1'b0}}, ybit};
        end else begin
            addend = ybit ? r_x : '0;
        end
        sum = {1'b0, half} + {1'b0, addend};
        if (sum >= {1'b0, i_m}) begin
            sum = sum - {1'b0, i_m};
        end
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_go) begin
            n_acc  = '0;
            n_cnt  = CW'(WIDTH - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = sum[WIDTH-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        if (i_go) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_red <= i_red;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_busy && (r_cnt == '0);
    assign o_res  = sum[WIDTH-1:0];
endmodule
`default_nettype wire

/* hw/rtl/msqrt_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msqrt_dp
// datapath: config, working registers, exponentiation registers, result
// ----------------------------------------------------------------------------
module msqrt_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [0:0]                   i_cfg_idx,
    input  wire logic [msqrt_pkg::WIDTH-1:0]  i_cfg_data,
    input  wire logic [msqrt_pkg::WIDTH-1:0]  i_value,
    input  wire logic                         i_stall,
    input  wire msqrt_pkg::t_cmd              i_cmd,
    output msqrt_pkg::t_stat                  o_stat,
    output logic                              o_valid,
    output logic      [msqrt_pkg::WIDTH-1:0]  o_root,
    output logic                              o_found
);
    import msqrt_pkg::*;

    logic [WIDTH-1:0] r_mod, r_nrcfg;
    logic [WIDTH-1:0] r_a, r_nr, r_q, r_b, r_x, r_t, r_u;
    logic [WIDTH-1:0] r_pr, r_px, r_pe;
    logic [CW-1:0]    r_c, r_cc;
    t_mop             r_mop;
    logic             r_ovalid;
    logic [WIDTH-1:0] r_root;
    logic             r_found;

    logic [WIDTH-1:0] mx, my, mres;
    logic             mred, mbusy, mdone;
    logic [WIDTH-1:0] pbase, pexp;
    logic [CW-1:0]    dshift;
    logic             out_free;

    always_comb begin
        mx   = '0;
        my   = '0;
        mred = 1'b0;
        case (i_cmd.mop)
            M_RED_A: begin
                my   = r_a;
                mred = 1'b1;
            end
            M_RED_NR: begin
                my   = r_nr;
                mred = 1'b1;
            end
            M_POW_R: begin
                mx = r_pr;
                my = r_px;
            end
            M_POW_X: begin
                mx = r_px;
                my = r_px;
            end
            M_U: begin
                mx = r_u;
                my = r_u;
            end
            M_XD: begin
                mx = r_x;
                my = r_pr;
            end
            M_DD: begin
                mx = r_pr;
                my = r_pr;
            end
            M_TB: begin
                mx = r_t;
                my = r_b;
            end
            default: begin
                mx = '0;
            end
        endcase
    end

    msqrt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mul_go),
        .i_red   (mred),
        .i_x     (mx),
        .i_y     (my),
        .i_m     (r_mod),
        .o_busy  (mbusy),
        .o_done  (mdone),
        .o_res   (mres)
    );

    always_comb begin
        dshift = r_c - r_cc - 1'b1;
        pbase  = r_a;
        pexp   = r_q;
        case (i_cmd.psel)
            P_AQ: begin
                pbase = r_a;
                pexp  = r_q;
            end
            P_AQH: begin
                pbase = r_a;
                pexp  = WIDTH'(({1'b0, r_q} + 1'b1) >> 1);
            end
            P_BQ: begin
                pbase = r_nr;
                pexp  = r_q;
            end
            P_BD: begin
                pbase = r_b;
                pexp  = {{(WIDTH-1){1'b0}}, 1'b1} << dshift;
            end
            default: begin
                pbase = r_a;
            end
        endcase
    end

    assign out_free = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod    <= WIDTH'(2);
            r_nrcfg  <= WIDTH'(1);
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODULUS: r_mod   <= i_cfg_data;
                    CFG_NONRES:  r_nrcfg <= i_cfg_data;
                    default:     r_mod   <= r_mod;
                endcase
            end
            if (i_cmd.out_go) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a  <= i_value;
            r_nr <= r_nrcfg;
        end
        if (i_cmd.q_half) begin
            r_q <= (r_mod - 1'b1) >> 1;
            r_c <= '0;
        end
        if (i_cmd.q_shift) begin
            r_q <= r_q >> 1;
            r_c <= r_c + 1'b1;
        end
        if (i_cmd.u_init) begin
            r_u  <= r_t;
            r_cc <= '0;
        end
        if (i_cmd.cc_inc) begin
            r_cc <= r_cc + 1'b1;
        end
        if (i_cmd.c_set) begin
            r_c <= r_cc;
        end
        if (i_cmd.mul_go) begin
            r_mop <= i_cmd.mop;
        end
        if (i_cmd.pow_go) begin
            r_pr <= WIDTH'(1);
            r_px <= pbase;
            r_pe <= pexp;
        end
        if (i_cmd.st_b) begin
            r_b <= r_pr;
        end
        if (i_cmd.st_x) begin
            r_x <= r_pr;
        end
        if (i_cmd.st_t) begin
            r_t <= r_pr;
        end
        if (mdone) begin
            case (r_mop)
                M_RED_A:  r_a  <= mres;
                M_RED_NR: r_nr <= mres;
                M_POW_R:  r_pr <= mres;
                M_POW_X: begin
                    r_px <= mres;
                    r_pe <= r_pe >> 1;
                end
                M_U:      r_u  <= mres;
                M_XD:     r_x  <= mres;
                M_DD:     r_b  <= mres;
                M_TB:     r_t  <= mres;
                default:  r_a  <= r_a;
            endcase
        end
        if (i_cmd.out_go) begin
            case (i_cmd.osel)
                O_A: begin
                    r_root  <= r_a;
                    r_found <= 1'b1;
                end
                O_X: begin
                    r_root  <= r_x;
                    r_found <= 1'b1;
                end
                default: begin
                    r_root  <= '0;
                    r_found <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.p_lt2    = r_mod < WIDTH'(2);
        o_stat.p_two    = r_mod == WIDTH'(2);
        o_stat.a_zero   = r_a == '0;
        o_stat.pe_zero  = r_pe == '0;
        o_stat.pe_lsb   = r_pe[0];
        o_stat.pr_one   = r_pr == WIDTH'(1);
        o_stat.q_lsb    = r_q[0];
        o_stat.t_one    = r_t == WIDTH'(1);
        o_stat.u_one    = r_u == WIDTH'(1);
        o_stat.cc_last  = ({1'b0, r_cc} + 1'b1) >= {1'b0, r_c};
        o_stat.mul_busy = mbusy;
        o_stat.mul_done = mdone;
        o_stat.out_free = out_free;
    end

    assign o_valid = r_ovalid;
    assign o_root  = r_root;
    assign o_found = r_found;
endmodule
`default_nettype wire

/* hw/rtl/msqrt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msqrt_ctrl
// sequencer for reduction, exponentiations and the tonelli-shanks loop
// ----------------------------------------------------------------------------
module msqrt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire msqrt_pkg::t_stat i_stat,
    output msqrt_pkg::t_cmd       o_cmd
);
    import msqrt_pkg::*;

    typedef enum logic [21:0] {
        S_IDLE   = 22'd1 << 0,
        S_CHK    = 22'd1 << 1,
        S_RED_A  = 22'd1 << 2,
        S_ZCHK   = 22'd1 << 3,
        S_EUL    = 22'd1 << 4,
        S_PCHK   = 22'd1 << 5,
        S_PMR    = 22'd1 << 6,
        S_PSQ    = 22'd1 << 7,
        S_PMX    = 22'd1 << 8,
        S_PRET   = 22'd1 << 9,
        S_QSH    = 22'd1 << 10,
        S_RED_NR = 22'd1 << 11,
        S_BINIT  = 22'd1 << 12,
        S_LOOP   = 22'd1 << 13,
        S_USQ    = 22'd1 << 14,
        S_MU     = 22'd1 << 15,
        S_UCHK   = 22'd1 << 16,
        S_MXD    = 22'd1 << 17,
        S_DDS    = 22'd1 << 18,
        S_MDD    = 22'd1 << 19,
        S_TBS    = 22'd1 << 20,
        S_MTB    = 22'd1 << 21
    } t_state;

    typedef enum logic [5:0] {
        PH_EULER = 6'b000001,
        PH_ROOT1 = 6'b000010,
        PH_B     = 6'b000100,
        PH_X     = 6'b001000,
        PH_T     = 6'b010000,
        PH_D     = 6'b100000
    } t_phase;

    typedef enum logic [3:0] {
        F_NONE = 4'b0001,
        F_A    = 4'b0010,
        F_X    = 4'b0100,
        F_FAIL = 4'b1000
    } t_fin;

    t_state r_state, n_state;
    t_phase r_ph, n_ph;
    t_fin   r_fin, n_fin;

    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_fin   = r_fin;
        o_cmd   = '0;
        o_cmd.mop  = M_RED_A;
        o_cmd.psel = P_AQ;
        o_cmd.osel = O_FAIL;
        if (r_fin != F_NONE) begin
            if (i_stat.out_free) begin
                o_cmd.out_go = 1'b1;
                case (r_fin)
                    F_A:     o_cmd.osel = O_A;
                    F_X:     o_cmd.osel = O_X;
                    default: o_cmd.osel = O_FAIL;
                endcase
                n_fin   = F_NONE;
                n_state = S_IDLE;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_CHK;
                    end
                end
                S_CHK: begin
                    if (i_stat.p_lt2) begin
                        n_fin = F_FAIL;
                    end else begin
                        o_cmd.mul_go = 1'b1;
                        o_cmd.mop    = M_RED_A;
                        n_state      = S_RED_A;
                    end
                end
                S_RED_A: begin
                    if (i_stat.mul_done) begin
                        n_state = S_ZCHK;
                    end
                end
                S_ZCHK: begin
                    if (i_stat.a_zero || i_stat.p_two) begin
                        n_fin = F_A;
                    end else begin
                        o_cmd.q_half = 1'b1;
                        n_state      = S_EUL;
                    end
                end
                S_EUL: begin
                    o_cmd.pow_go = 1'b1;
                    o_cmd.psel   = P_AQ;
                    n_ph         = PH_EULER;
                    n_state      = S_PCHK;
                end
                S_PCHK: begin
                    if (i_stat.pe_zero) begin
                        n_state = S_PRET;
                    end else if (i_stat.pe_lsb) begin
                        o_cmd.mul_go = 1'b1;
                        o_cmd.mop    = M_POW_R;
                        n_state      = S_PMR;
                    end else begin
                        o_cmd.mul_go = 1'b1;
                        o_cmd.mop    = M_POW_X;
                        n_state      = S_PMX;
                    end
                end
                S_PMR: begin
                    if (i_stat.mul_done) begin
                        n_state = S_PSQ;
                    end
                end
                S_PSQ: begin
                    o_cmd.mul_go = 1'b1;
                    o_cmd.mop    = M_POW_X;
                    n_state      = S_PMX;
                end
                S_PMX: begin
                    if (i_stat.mul_done) begin
                        n_state = S_PCHK;
                    end
                end
                S_PRET: begin
                    case (r_ph)
                        PH_EULER: begin
                            if (!i_stat.pr_one) begin
                                n_fin = F_FAIL;
                            end else if (i_stat.q_lsb) begin
                                o_cmd.pow_go = 1'b1;
                                o_cmd.psel   = P_AQH;
                                n_ph         = PH_ROOT1;
                                n_state      = S_PCHK;
                            end else begin
                                n_state = S_QSH;
                            end
                        end
                        PH_ROOT1: begin
                            o_cmd.st_x = 1'b1;
                            n_fin      = F_X;
                        end
                        PH_B: begin
                            o_cmd.st_b   = 1'b1;
                            o_cmd.pow_go = 1'b1;
                            o_cmd.psel   = P_AQH;
                            n_ph         = PH_X;
                            n_state      = S_PCHK;
                        end
                        PH_X: begin
                            o_cmd.st_x   = 1'b1;
                            o_cmd.pow_go = 1'b1;
                            o_cmd.psel   = P_AQ;
                            n_ph         = PH_T;
                            n_state      = S_PCHK;
                        end
                        PH_T: begin
                            o_cmd.st_t = 1'b1;
                            n_state    = S_LOOP;
                        end
                        PH_D: begin
                            o_cmd.mul_go = 1'b1;
                            o_cmd.mop    = M_XD;
                            n_state      = S_MXD;
                        end
                        default: begin
                            n_fin = F_FAIL;
                        end
                    endcase
                end
                S_QSH: begin
                    if (i_stat.q_lsb) begin
                        o_cmd.mul_go = 1'b1;
                        o_cmd.mop    = M_RED_NR;
                        n_state      = S_RED_NR;
                    end else begin
                        o_cmd.q_shift = 1'b1;
                    end
                end
                S_RED_NR: begin
                    if (i_stat.mul_done) begin
                        n_state = S_BINIT;
                    end
                end
                S_BINIT: begin
                    o_cmd.pow_go = 1'b1;
                    o_cmd.psel   = P_BQ;
                    n_ph         = PH_B;
                    n_state      = S_PCHK;
                end
                S_LOOP: begin
                    if (i_stat.t_one) begin
                        n_fin = F_X;
                    end else begin
                        o_cmd.u_init = 1'b1;
                        n_state      = S_USQ;
                    end
                end
                S_USQ: begin
                    o_cmd.mul_go = 1'b1;
                    o_cmd.mop    = M_U;
                    n_state      = S_MU;
                end
                S_MU: begin
                    if (i_stat.mul_done) begin
                        n_state = S_UCHK;
                    end
                end
                S_UCHK: begin
                    if (i_stat.u_one) begin
                        o_cmd.pow_go = 1'b1;
                        o_cmd.psel   = P_BD;
                        n_ph         = PH_D;
                        n_state      = S_PCHK;
                    end else if (i_stat.cc_last) begin
                        n_fin = F_FAIL;
                    end else begin
                        o_cmd.cc_inc = 1'b1;
                        n_state      = S_USQ;
                    end
                end
                S_MXD: begin
                    if (i_stat.mul_done) begin
                        n_state = S_DDS;
                    end
                end
                S_DDS: begin
                    o_cmd.mul_go = 1'b1;
                    o_cmd.mop    = M_DD;
                    n_state      = S_MDD;
                end
                S_MDD: begin
                    if (i_stat.mul_done) begin
                        n_state = S_TBS;
                    end
                end
                S_TBS: begin
                    o_cmd.mul_go = 1'b1;
                    o_cmd.mop    = M_TB;
                    o_cmd.c_set  = 1'b1;
                    n_state      = S_MTB;
                end
                S_MTB: begin
                    if (i_stat.mul_done) begin
                        n_state = S_LOOP;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= PH_EULER;
            r_fin   <= F_NONE;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_fin   <= n_fin;
        end
    end

    assign o_stall = !((r_state == S_IDLE) && (r_fin == F_NONE));
endmodule
`default_nettype wire

/* hw/rtl/modular_square_root.sv */
`default_nettype none
// run time: shortest for a modulus below two, longer for a zero value or modulus
// two, longest when p - 1 has a long run of trailing zeros; set by the shared
// bit-serial multiplier
// throughput: one item at a time; the next item is taken once the result is
// registered, while that result may still wait at the output
// reset: synchronous active low; modulus returns to 2 and nonresidue to 1
// ----------------------------------------------------------------------------
// modular_square_root
// tonelli-shanks modular square root with a configured prime and nonresidue
// ----------------------------------------------------------------------------
`include "modular_square_root_assert.svh"
module modular_square_root (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [0:0]                   i_cfg_idx,
    input  wire logic [msqrt_pkg::WIDTH-1:0]  i_cfg_data,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [msqrt_pkg::WIDTH-1:0]  i_value,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [msqrt_pkg::WIDTH-1:0]  o_root,
    output logic                              o_found
);
    import msqrt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    msqrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    msqrt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_value    (i_value),
        .i_stall    (i_stall),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .o_root     (o_root),
        .o_found    (o_found)
    );

    `MSQRT_ASSERT_IMPL(a_out_free, i_clk, i_rst_n, cmd.out_go, stat.out_free)
    `MSQRT_ASSERT_IMPL(a_mul_idle, i_clk, i_rst_n, cmd.mul_go, !stat.mul_busy)
    `MSQRT_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, o_valid && !o_found, o_root == '0)
    `MSQRT_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
endmodule
`default_nettype wire

/* sim/modular_square_root_tb.sv */
// ----------------------------------------------------------------------------
// modular_square_root_tb
// drives residues into the tonelli-shanks square root block under several
// prime and nonresidue settings and checks each root and found flag
// against a predictor that keeps its own copy of the configuration
// ----------------------------------------------------------------------------
class msqrt_scoreboard;
    logic [msqrt_pkg::WIDTH-1:0] root_q[$];
    logic                        found_q[$];
    int                          errors;
    int                          checked;

    function new();
        errors  = 0;
        checked = 0;
    endfunction

    function void note_item(logic [msqrt_pkg::WIDTH-1:0] r, logic f);
        root_q.push_back(r);
        found_q.push_back(f);
    endfunction

    function void check_result(logic [msqrt_pkg::WIDTH-1:0] r, logic f);
        logic [msqrt_pkg::WIDTH-1:0] er;
        logic                        ef;
        if (root_q.size() == 0) begin
            $error("unexpected result root=%0d found=%0d", r, f);
            errors++;
            return;
        end
        er = root_q.pop_front();
        ef = found_q.pop_front();
        checked++;
        if (r !== er) begin
            $error("root expected %0d actual %0d", er, r);
            errors++;
        end
        if (f !== ef) begin
            $error("found expected %0d actual %0d", ef, f);
            errors++;
        end
    endfunction

    function int pending();
        return root_q.size();
    endfunction
endclass

module modular_square_root_tb;
    import msqrt_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [0:0]       i_cfg_idx;
    logic [WIDTH-1:0] i_cfg_data;
    logic             i_valid;
    logic             o_stall;
    logic [WIDTH-1:0] i_value;
    logic             o_valid;
    logic             i_stall;
    logic [WIDTH-1:0] o_root;
    logic             o_found;

    logic [63:0] cur_p;
    logic [63:0] cur_nr;
    msqrt_scoreboard sb;
    bit          rx_quiet;
    int          stall_left;

    modular_square_root i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_value(i_value),
        .o_valid(o_valid), .i_stall(i_stall), .o_root(o_root), .o_found(o_found)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400000000;
        $display("modular_square_root_tb failed");
        $finish;
    end

    function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y,
                                           logic [63:0] m);
        logic [63:0] r;
        r = 0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            r = r + r;
            if (r >= m) r = r - m;
            if (y[i]) begin
                r = r + x;
                if (r >= m) r = r - m;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] powmod(logic [63:0] x, logic [63:0] e,
                                           logic [63:0] m);
        logic [63:0] r;
        r = 1 % m;
        while (e != 0) begin
            if (e[0]) r = mulmod(r, x, m);
            e = e >> 1;
            x = mulmod(x, x, m);
        end
        return r;
    endfunction

    function automatic void predict_root(logic [63:0] a, output logic [WIDTH-1:0] root,
                                         output logic found);
        logic [63:0] p, q, b, x, t, u, d;
        int          c, cc;
        bit          done;
        p = cur_p;
        root = '0;
        found = 1'b0;
        if (p < 2) return;
        a = a % p;
        if (a == 0 || p == 2) begin
            root = a[WIDTH-1:0];
            found = 1'b1;
            return;
        end
        q = (p - 1) >> 1;
        if (powmod(a, q, p) != 1) return;
        if (q[0]) begin
            x = powmod(a, (q + 1) >> 1, p);
            root = x[WIDTH-1:0];
            found = 1'b1;
            return;
        end
        c = 0;
        while (!q[0]) begin
            q = q >> 1;
            c++;
        end
        b = powmod(cur_nr % p, q, p);
        x = powmod(a, (q + 1) >> 1, p);
        t = powmod(a, q, p);
        while (t != 1) begin
            u = t;
            cc = 0;
            done = 0;
            while (!done) begin
                u = mulmod(u, u, p);
                if (u == 1) done = 1;
                else begin
                    cc++;
                    if (cc >= c) return;
                end
            end
            d = powmod(b, 64'd1 << (c - cc - 1), p);
            x = mulmod(x, d, p);
            b = mulmod(d, d, p);
            t = mulmod(t, b, p);
            c = cc;
        end
        root = x[WIDTH-1:0];
        found = 1'b1;
    endfunction

    task automatic write_reg(logic [0:0] idx, logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[WIDTH-1:0];
        @(posedge i_clk);
        if (idx == CFG_MODULUS) cur_p = 64'(data[WIDTH-1:0]);
        else cur_nr = 64'(data[WIDTH-1:0]);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (sb.pending() != 0 && guard < 2000000) begin
            @(posedge i_clk);
            guard++;
        end
        if (sb.pending() != 0) begin
            $display("modular_square_root_tb failed");
            $finish;
        end
        repeat (50) @(posedge i_clk);
    endtask

    task automatic send_value(logic [63:0] a);
        logic [WIDTH-1:0] r;
        logic             f;
        int               gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                          : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= a[WIDTH-1:0];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_root(a[WIDTH-1:0], r, f);
        sb.note_item(r, f);
    endtask

    task automatic configure(logic [63:0] p, logic [63:0] nr);
        drain();
        write_reg(CFG_MODULUS, p);
        write_reg(CFG_NONRES, nr);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand_below(logic [63:0] p);
        if ($urandom_range(0, 7) == 0) return 64'($urandom & 32'h7fff_ffff);
        return {32'd0, $urandom} % p;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_result(o_root, o_found);
            if (rx_quiet) begin
                stall_left = 0;
                i_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                         : $urandom_range(0, 3);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        logic [63:0] primes[6];
        logic [63:0] nrs[6];
        sb = new();
        rx_quiet   = 0;
        stall_left = 0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_value    = '0;
        i_stall    = 1'b0;
        cur_p  = 2;
        cur_nr = 1;
        // p, matching nonresidue; mix of p = 3 mod 4 and deep 2-adic primes
        primes = '{64'd2147483647, 64'd2013265921, 64'd17, 64'd97, 64'd65537, 64'd13};
        nrs    = '{64'd7, 64'd31, 64'd3, 64'd5, 64'd3, 64'd2};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // reset settings: modulus two returns the value reduced
        send_value(0);
        send_value(1);
        send_value(64'h7fff_ffff);
        configure(1, 1);
        send_value(5);
        send_value(0);
        configure(primes[0], nrs[0]);
        send_value(0);
        send_value(4);
        send_value(2147483646);
        send_value(64'h7fff_ffff);
        send_value(7);
        configure(primes[1], nrs[1]);
        send_value(4);
        send_value(31);
        send_value(2013265920);
        send_value(64'h7fff_ffff);
        configure(17, 20);
        send_value(2);
        send_value(15);
        send_value(3);
        configure(21, 2);
        send_value(4);
        send_value(16);
        configure(17, 2);
        send_value(13);
        send_value(9);
        for (int ph = 0; ph < 6; ph++) begin
            configure(primes[ph], nrs[ph]);
            if (ph == 3) begin
                rx_quiet = 1;
                drain();
                rx_quiet = 0;
            end
            for (int n = 0; n < 25; n++) send_value(rand_below(primes[ph]));
        end
        drain();
        $display("covered %0d roots over six primes, modulus two and one, bad nonresidue",
                 sb.checked);
        $display("and a composite modulus with random stalls on both sides");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("modular_square_root_tb passed");
        end else begin
            $display("modular_square_root_tb failed");
        end
        $finish;
    end
endmodule
